// ===== hdl/sha1_message_hash_defines.svh =====
// Assertion macros shared by the checker.
// No dependencies.
`ifndef SHA1_MESSAGE_HASH_DEFINES_SVH
`define SHA1_MESSAGE_HASH_DEFINES_SVH
// implication, disabled while the active-low reset is asserted
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hdl/sha_pkg.sv =====
// Types and constants of the SHA-1 message hash.
// No dependencies.
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    // control from sequencer to round datapath
    typedef struct packed {
        logic       load;   // copy chain value into working vars
        logic       round;  // perform one round
        logic [6:0] t;      // round number
        logic       fold;   // add working vars into chain value
        logic       iv;     // restore initial vector
    } t_rnd_ctl;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;
    localparam logic [31:0] K0  = 32'h5a827999;
    localparam logic [31:0] K1  = 32'h6ed9eba1;
    localparam logic [31:0] K2  = 32'h8f1bbcdc;
    localparam logic [31:0] K3  = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction
endpackage

// ===== hdl/sha1_message_hash.sv =====
// SHA-1 hash of a byte stream, top level; depends on sha_pkg and sha_round.
// Throughput: one byte beat a cycle while o_stall is low; the 64th byte of a block
// stalls input through working-variable load, 80 rounds and fold.
// End of message: padding goes in a byte a cycle up to the block end, then one or two
// blocks are compressed before the first digest beat.
// Five digest beats, one a cycle unless stalled. Reset restores the initial vector.
module sha1_message_hash import sha_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_PRE = 3'd2,
                           S_RND  = 3'd3, S_FOLD = 3'd4, S_OUT = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_ending;   // end of message taken, padding owed
    logic        r_padded;   // 0x80 already written
    logic        r_lenblk;   // current block carries the length field
    logic [6:0]  r_t;
    logic [2:0]  r_oidx;

    // block buffer and schedule window share one 16-word memory
    logic [31:0] r_win [16];
    logic [31:0] r_p3, r_p8, r_p14, r_p16; // registered taps for the coming round
    logic [3:0]  rd_base;
    logic [31:0] wnew, w_t;
    t_rnd_ctl    ctl;
    logic [31:0] chain;
    logic        acc, wr_en, blk_full;
    logic [7:0]  wr_byte, pad_b;
    logic [63:0] len_sh;

    assign o_stall = (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;

    // length bytes go out big-endian at fill 56..63
    assign len_sh = r_bits >> {3'd7 - r_fill[2:0], 3'd0};

    always_comb begin
        if (!r_padded)                        pad_b = PAD_BYTE;
        else if (r_lenblk && r_fill >= 6'd56) pad_b = len_sh[7:0];
        else                                  pad_b = 8'd0;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_byte = i_data.data_byte;
        if (r_state == S_IDLE && acc && i_data.has_byte) wr_en = 1'b1;
        if (r_state == S_PAD) begin
            wr_en   = 1'b1;
            wr_byte = pad_b;
        end
    end

    assign blk_full = wr_en && (r_fill == 6'd63);

    // taps are registered in the cycle before their round; round t writes slot t, never a tap of t+1
    assign rd_base = (r_state == S_RND) ? r_t[3:0] + 4'd1 : 4'd0;
    assign wnew    = rol(r_p3 ^ r_p8 ^ r_p14 ^ r_p16, 5'd1);
    assign w_t     = (r_t < 7'd16) ? r_p16 : wnew;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (r_fill[1:0])
                2'd0:    r_win[r_fill[5:2]][31:24] <= wr_byte;
                2'd1:    r_win[r_fill[5:2]][23:16] <= wr_byte;
                2'd2:    r_win[r_fill[5:2]][15:8]  <= wr_byte;
                default: r_win[r_fill[5:2]][7:0]   <= wr_byte;
            endcase
        end else if (r_state == S_RND && r_t >= 7'd16) begin
            r_win[r_t[3:0]] <= wnew;
        end
        r_p3  <= r_win[rd_base + 4'd13];
        r_p8  <= r_win[rd_base + 4'd8];
        r_p14 <= r_win[rd_base + 4'd2];
        r_p16 <= r_win[rd_base];
    end

    always_comb begin
        ctl.load  = (r_state == S_PRE);
        ctl.round = (r_state == S_RND);
        ctl.t     = r_t;
        ctl.fold  = (r_state == S_FOLD);
        ctl.iv    = (r_state == S_OUT) && !i_stall && (r_oidx == 3'd4);
    end

    sha_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_w(w_t),
        .i_rd_idx(r_oidx), .o_chain(chain)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && blk_full)                   n_state = S_PRE;
                else if (acc && i_data.end_of_message) n_state = S_PAD;
            end
            S_PAD:  if (r_fill == 6'd63) n_state = S_PRE;
            S_PRE:  n_state = S_RND;
            S_RND:  if (r_t == 7'd79) n_state = S_FOLD;
            S_FOLD: begin
                if (!r_ending)                 n_state = S_IDLE;
                else if (r_padded && r_lenblk) n_state = S_OUT;
                else                           n_state = S_PAD;
            end
            S_OUT:  if (!i_stall && r_oidx == 3'd4) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_bits <= '0; r_ending <= 1'b0;
            r_padded <= 1'b0; r_lenblk <= 1'b0; r_t <= '0; r_oidx <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) r_fill <= r_fill + 6'd1;
            if (r_state == S_IDLE && acc) begin
                if (i_data.has_byte) r_bits <= r_bits + 64'd8;
                r_ending <= i_data.end_of_message;
            end
            // 0x80 at fill 56 or above pushes the length into a further block
            if (r_state == S_PAD && !r_padded) begin
                r_padded <= 1'b1;
                r_lenblk <= (r_fill < 6'd56);
            end
            if (r_state == S_PRE) r_t <= '0;
            if (r_state == S_RND) r_t <= r_t + 7'd1;
            if (r_state == S_FOLD) begin
                r_oidx <= '0;
                if (r_ending && r_padded) r_lenblk <= 1'b1;
            end
            if (r_state == S_OUT && !i_stall) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd4) begin
                    r_bits <= '0; r_ending <= 1'b0; r_padded <= 1'b0; r_lenblk <= 1'b0;
                end
            end
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_data  = '{digest_word: chain, word_index: r_oidx, last_word: (r_oidx == 3'd4)};
endmodule

// ===== hdl/sha_round.sv =====
// SHA-1 round datapath: working variables and chaining value.
// Depends on sha_pkg.
module sha_round import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rnd_ctl    i_ctl,
    input  logic [31:0] i_w,
    input  logic [2:0]  i_rd_idx,
    output logic [31:0] o_chain
);
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] f, k, tmp;

    always_comb begin
        if (i_ctl.t < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (i_ctl.t < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (i_ctl.t < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        tmp = rol(r_a, 5'd5) + f + r_e + i_w + k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3; r_h[4] <= IV4;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0;
        end else begin
            if (i_ctl.load) begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                r_d <= r_h[3]; r_e <= r_h[4];
            end else if (i_ctl.round) begin
                r_e <= r_d; r_d <= r_c; r_c <= rol(r_b, 5'd30);
                r_b <= r_a; r_a <= tmp;
            end
            if (i_ctl.fold) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (i_ctl.iv) begin
                r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2;
                r_h[3] <= IV3; r_h[4] <= IV4;
            end
        end
    end

    always_comb begin
        case (i_rd_idx)
            3'd0:    o_chain = r_h[0];
            3'd1:    o_chain = r_h[1];
            3'd2:    o_chain = r_h[2];
            3'd3:    o_chain = r_h[3];
            default: o_chain = r_h[4];
        endcase
    end
endmodule

// ===== hdl/sha_checker.sv =====
// Port-level checker for the SHA-1 hash block, bound to the top level.
// Depends on sha_pkg and sha1_message_hash_defines.svh.
`include "sha1_message_hash_defines.svh"
module sha_checker import sha_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_beat o_data
);
    logic out_acc;
    assign out_acc = o_valid && !i_stall;

    `SHA_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid && o_data.last_word,
                    o_data.word_index == 3'd4)
    `SHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `SHA_ASSERT_NXT(a_step, i_clk, i_rst_n, out_acc && !o_data.last_word,
                    o_valid && o_data.word_index == $past(o_data.word_index) + 3'd1)
endmodule

bind sha1_message_hash sha_checker u_chk (.*);
